>>> hdl/teq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the timed event queue.
// Used by the channel interfaces, the storage cell and the top level.
package teq_pkg;

	localparam int SEC_W = 32;
	localparam int NSEC_W = 30;
	localparam int TAG_W = 16;
	localparam int CMD_W = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 5;

	localparam int DEPTH_DEF = 16;
	localparam int TAG_BITS_DEF = 16;
	// A release command hands out at most this many events.
	localparam int MAX_REL = 16;
	localparam int REL_W = $clog2(MAX_REL);

	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
	localparam logic [CMD_W-1:0] CMD_COMPARE = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_NONE_DUE = 2'd3;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_SHIFT
	} cell_op_t;

	// Broadcast to every cell of the chain in each cycle.
	typedef struct packed {
		cell_op_t op;
		logic [SEC_W-1:0] sec;
		logic [NSEC_W-1:0] nsec;
	} cell_ctrl_t;

	// True when time a is strictly before time b.
	function automatic logic time_before(
		input logic [SEC_W-1:0] a_sec,
		input logic [NSEC_W-1:0] a_nsec,
		input logic [SEC_W-1:0] b_sec,
		input logic [NSEC_W-1:0] b_nsec
	);
		return (a_sec < b_sec) || ((a_sec == b_sec) && (a_nsec < b_nsec));
	endfunction

endpackage

>>> hdl/teq_req_if.sv
`timescale 1ns / 1ps
// Command channel of the timed event queue: valid/ready plus one command beat.
// Depends on teq_pkg for the field widths.
interface teq_req_if import teq_pkg::*; ();
	logic valid;
	logic ready;
	logic [CMD_W-1:0] cmd;
	logic [SEC_W-1:0] time_sec;
	logic [NSEC_W-1:0] time_nsec;
	logic [TAG_W-1:0] tag;

	modport source (output valid, cmd, time_sec, time_nsec, tag, input ready);
	modport sink (input valid, cmd, time_sec, time_nsec, tag, output ready);
endinterface

>>> hdl/teq_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the timed event queue: valid/ready plus one result beat.
// Depends on teq_pkg for the field widths.
interface teq_rsp_if import teq_pkg::*; ();
	logic valid;
	logic ready;
	logic [STATUS_W-1:0] status;
	logic [TAG_W-1:0] out_tag;
	logic [SEC_W-1:0] out_sec;
	logic [NSEC_W-1:0] out_nsec;
	logic earlier;
	logic [COUNT_W-1:0] count;
	logic last;

	modport source (output valid, status, out_tag, out_sec, out_nsec, earlier, count, last,
		input ready);
	modport sink (input valid, status, out_tag, out_sec, out_nsec, earlier, count, last,
		output ready);
endinterface

>>> hdl/teq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted event chain: holds a timestamp and tag and trades
// entries with its neighbors on insert and head removal. Depends on teq_pkg.
module teq_cell import teq_pkg::*; #(
	parameter int STORE_W = TAG_W
) (
	input logic clk,
	input cell_ctrl_t ctrl,
	input logic [STORE_W-1:0] new_tag,
	input logic valid,
	input logic prev_cond,
	input logic [SEC_W-1:0] prev_sec,
	input logic [NSEC_W-1:0] prev_nsec,
	input logic [STORE_W-1:0] prev_tag,
	input logic [SEC_W-1:0] next_sec,
	input logic [NSEC_W-1:0] next_nsec,
	input logic [STORE_W-1:0] next_tag,
	output logic cond,
	output logic [SEC_W-1:0] sec,
	output logic [NSEC_W-1:0] nsec,
	output logic [STORE_W-1:0] tag
);
	logic [SEC_W-1:0] sec_q;
	logic [NSEC_W-1:0] nsec_q;
	logic [STORE_W-1:0] tag_q;

	// The new event belongs at or before this slot when the slot is empty or
	// holds a strictly later time, so equal times keep arrival order.
	assign cond = !valid || time_before(ctrl.sec, ctrl.nsec, sec_q, nsec_q);

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_INSERT: begin
				if (prev_cond) begin
					sec_q <= prev_sec;
					nsec_q <= prev_nsec;
					tag_q <= prev_tag;
				end else if (cond) begin
					sec_q <= ctrl.sec;
					nsec_q <= ctrl.nsec;
					tag_q <= new_tag;
				end
			end
			OP_SHIFT: begin
				sec_q <= next_sec;
				nsec_q <= next_nsec;
				tag_q <= next_tag;
			end
			default: begin
			end
		endcase
	end

	assign sec = sec_q;
	assign nsec = nsec_q;
	assign tag = tag_q;
endmodule

>>> hdl/timed_event_queue_core.sv
`timescale 1ns / 1ps
// Top level of the timed event queue: a chain of sorted cells, the command
// sequencer and the result register. Depends on teq_pkg, teq_cell and the interfaces.
//
// Usage: commands arrive as beats on req and results leave as beats on rsp.
// Insert, pop, clear and compare each give one result beat, registered, on the
// cycle after the command is accepted. Release gives one beat per due event, one
// per cycle while the result register is free, with last on the final beat; at most 16
// events leave per release, and an empty queue or a not yet due head gives a
// single status beat. The first release beat comes only after the release state is
// entered, later than the result of the other commands, as the accept cycle
// only latches the time. The sorted insert needs no search because every cell
// compares the new time with its own entry in parallel; release drains the
// head of the chain one entry a cycle while the result register is free. A
// command with no result (codes 5 to 7) is absorbed in its accept cycle. One
// command is in work at a time: req.ready is low while a release drains and
// while a result beat waits with rsp.ready low, and the chain freezes until the
// receiver takes the beat. A command is taken in the same cycle its
// predecessor's last beat is taken. Reset empties the queue and drops any
// pending result; slot contents are not cleared.
module timed_event_queue_core import teq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	teq_req_if.sink req,
	teq_rsp_if.source rsp
);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int STORE_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'b01,
		FSM_REL = 2'b10
	} fsm_t;

	fsm_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [REL_W-1:0] rel_k_q, rel_k_d;
	logic [SEC_W-1:0] ref_sec_q;
	logic [NSEC_W-1:0] ref_nsec_q;

	logic out_valid_q;
	logic [STATUS_W-1:0] status_q, status_d;
	logic [STORE_W-1:0] tag_q, tag_d;
	logic [SEC_W-1:0] sec_q, sec_d;
	logic [NSEC_W-1:0] nsec_q, nsec_d;
	logic earlier_q, earlier_d;
	logic [COUNT_W-1:0] cnt_out_q, cnt_out_d;
	logic last_q, last_d;

	logic out_free, accept, load;
	cell_ctrl_t ctrl;

	logic valid_v [DEPTH];
	logic cond_v [DEPTH];
	logic [SEC_W-1:0] c_sec [DEPTH];
	logic [NSEC_W-1:0] c_nsec [DEPTH];
	logic [STORE_W-1:0] c_tag [DEPTH];

	logic head_due, second_due, rel_last;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam int PREV = (i == 0) ? 0 : i - 1;
		localparam int NEXT = (i == DEPTH - 1) ? i : i + 1;

		assign valid_v[i] = CNT_W'(i) < count_q;

		teq_cell #(
			.STORE_W(STORE_W)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.new_tag(STORE_W'(req.tag)),
			.valid(valid_v[i]),
			.prev_cond((i == 0) ? 1'b0 : cond_v[PREV]),
			.prev_sec(c_sec[PREV]),
			.prev_nsec(c_nsec[PREV]),
			.prev_tag(c_tag[PREV]),
			.next_sec(c_sec[NEXT]),
			.next_nsec(c_nsec[NEXT]),
			.next_tag(c_tag[NEXT]),
			.cond(cond_v[i]),
			.sec(c_sec[i]),
			.nsec(c_nsec[i]),
			.tag(c_tag[i])
		);
	end

	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == FSM_IDLE) && out_free;
	assign accept = req.valid && req.ready;

	assign head_due = !time_before(ref_sec_q, ref_nsec_q, c_sec[0], c_nsec[0]);
	assign second_due = !time_before(ref_sec_q, ref_nsec_q, c_sec[1], c_nsec[1]);
	assign rel_last = (rel_k_q == REL_W'(MAX_REL - 1)) || (count_q == CNT_W'(1)) ||
		!second_due;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		rel_k_d = rel_k_q;
		load = 1'b0;
		status_d = STAT_OK;
		tag_d = '0;
		sec_d = '0;
		nsec_d = '0;
		earlier_d = 1'b0;
		cnt_out_d = COUNT_W'(count_q);
		last_d = 1'b1;
		ctrl.op = OP_HOLD;
		ctrl.sec = req.time_sec;
		ctrl.nsec = req.time_nsec;

		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					unique case (req.cmd)
						CMD_INSERT: begin
							load = 1'b1;
							if (count_q == CNT_W'(DEPTH)) begin
								status_d = STAT_FULL;
							end else begin
								ctrl.op = OP_INSERT;
								count_d = count_q + CNT_W'(1);
								cnt_out_d = COUNT_W'(count_d);
							end
						end
						CMD_RELEASE: begin
							state_d = FSM_REL;
							rel_k_d = '0;
						end
						CMD_POP: begin
							load = 1'b1;
							if (count_q == '0) begin
								status_d = STAT_EMPTY;
							end else begin
								ctrl.op = OP_SHIFT;
								count_d = count_q - CNT_W'(1);
								cnt_out_d = COUNT_W'(count_d);
								tag_d = c_tag[0];
								sec_d = c_sec[0];
								nsec_d = c_nsec[0];
							end
						end
						CMD_CLEAR: begin
							load = 1'b1;
							count_d = '0;
						end
						CMD_COMPARE: begin
							load = 1'b1;
							if (count_q == '0) begin
								status_d = STAT_EMPTY;
							end else begin
								earlier_d = time_before(c_sec[0], c_nsec[0],
									req.time_sec, req.time_nsec);
							end
						end
						default: begin
						end
					endcase
				end
			end
			FSM_REL: begin
				if (out_free) begin
					load = 1'b1;
					if (count_q == '0) begin
						status_d = STAT_EMPTY;
						state_d = FSM_IDLE;
					end else if (!head_due) begin
						// Only reachable on the first step; later steps stop
						// early through rel_last.
						status_d = STAT_NONE_DUE;
						state_d = FSM_IDLE;
					end else begin
						ctrl.op = OP_SHIFT;
						count_d = count_q - CNT_W'(1);
						cnt_out_d = COUNT_W'(count_d);
						tag_d = c_tag[0];
						sec_d = c_sec[0];
						nsec_d = c_nsec[0];
						last_d = rel_last;
						if (rel_last) begin
							state_d = FSM_IDLE;
						end else begin
							rel_k_d = rel_k_q + REL_W'(1);
						end
					end
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			count_q <= '0;
			rel_k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rel_k_q <= rel_k_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ref_sec_q <= req.time_sec;
			ref_nsec_q <= req.time_nsec;
		end
		if (load) begin
			status_q <= status_d;
			tag_q <= tag_d;
			sec_q <= sec_d;
			nsec_q <= nsec_d;
			earlier_q <= earlier_d;
			cnt_out_q <= cnt_out_d;
			last_q <= last_d;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = status_q;
	assign rsp.out_tag = TAG_W'(tag_q);
	assign rsp.out_sec = sec_q;
	assign rsp.out_nsec = nsec_q;
	assign rsp.earlier = earlier_q;
	assign rsp.count = cnt_out_q;
	assign rsp.last = last_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("occupancy above queue depth");

	a_rel_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_REL) |-> !req.ready)
		else $error("command taken while a release drains");

	a_last_ends_rel: assert property (@(posedge clk) disable iff (!arst_n)
		(load && last_d && (state_q == FSM_REL)) |=> (state_q == FSM_IDLE))
		else $error("release kept running after its last beat");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> !time_before(c_sec[1], c_nsec[1], c_sec[0], c_nsec[0]))
		else $error("queue head is later than the second entry");
`endif
endmodule

>>> sim/tb_timed_event_queue_core.sv
`timescale 1ns / 1ps
// Self-checking bench for timed_event_queue_core: a queue-model scoreboard predicts
// every result beat from the accepted commands. Needs teq_pkg, both channel interfaces and the core.
module tb_timed_event_queue_core;
	import teq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int TAG_BITS = TAG_BITS_DEF;
	localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_COMPARE + 3'd1;
	localparam logic [NSEC_W-1:0] NSEC_LEGAL_MAX = 30'd999_999_999;
	localparam int RANDOM_ITEMS = 120;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 20;
	localparam int IDLE_LIMIT = 4000;

	typedef struct packed {
		logic [SEC_W-1:0] sec;
		logic [NSEC_W-1:0] nsec;
		logic [TAG_W-1:0] tag;
	} queued_evt_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TAG_W-1:0] tag;
		logic [SEC_W-1:0] sec;
		logic [NSEC_W-1:0] nsec;
		logic earlier;
		logic [COUNT_W-1:0] count;
		logic last;
	} result_beat_t;

	class event_scoreboard;
		queued_evt_t held_events[$];
		result_beat_t due_beats[$];
		int mismatches = 0;

		// Strict ordering: seconds first, then nanoseconds.
		function bit ahead_of(logic [SEC_W-1:0] as, logic [NSEC_W-1:0] an,
				logic [SEC_W-1:0] bs, logic [NSEC_W-1:0] bn);
			return (as < bs) || (as == bs && an < bn);
		endfunction

		function void add_beat(logic [STATUS_W-1:0] st, queued_evt_t ev, logic earl,
				int cnt, logic lst);
			result_beat_t b;
			b.status = st;
			b.tag = ev.tag;
			b.sec = ev.sec;
			b.nsec = ev.nsec;
			b.earlier = earl;
			b.count = cnt[COUNT_W-1:0];
			b.last = lst;
			due_beats.push_back(b);
		endfunction

		function void note_command(logic [CMD_W-1:0] c, logic [SEC_W-1:0] s,
				logic [NSEC_W-1:0] ns, logic [TAG_W-1:0] tg);
			queued_evt_t ev;
			queued_evt_t blank;
			int pos;
			int k;
			blank = '0;
			ev.sec = s;
			ev.nsec = ns;
			ev.tag = tg & TAG_W'((64'd1 << TAG_BITS) - 64'd1);
			case (c)
				CMD_INSERT: begin
					if (held_events.size() >= DEPTH) begin
						add_beat(STAT_FULL, blank, 1'b0, held_events.size(), 1'b1);
					end else begin
						// Equal times go behind the ones already queued.
						pos = 0;
						while (pos < held_events.size() &&
								!ahead_of(s, ns, held_events[pos].sec, held_events[pos].nsec))
							pos++;
						held_events.insert(pos, ev);
						add_beat(STAT_OK, blank, 1'b0, held_events.size(), 1'b1);
					end
				end
				CMD_RELEASE: begin
					if (held_events.size() == 0) begin
						add_beat(STAT_EMPTY, blank, 1'b0, 0, 1'b1);
					end else begin
						k = 0;
						while (k < MAX_REL && held_events.size() > 0 &&
								!ahead_of(s, ns, held_events[0].sec, held_events[0].nsec)) begin
							ev = held_events.pop_front();
							add_beat(STAT_OK, ev, 1'b0, held_events.size(), 1'b0);
							k++;
						end
						if (k == 0)
							add_beat(STAT_NONE_DUE, blank, 1'b0, held_events.size(), 1'b1);
						else
							due_beats[due_beats.size() - 1].last = 1'b1;
					end
				end
				CMD_POP: begin
					if (held_events.size() == 0) begin
						add_beat(STAT_EMPTY, blank, 1'b0, 0, 1'b1);
					end else begin
						ev = held_events.pop_front();
						add_beat(STAT_OK, ev, 1'b0, held_events.size(), 1'b1);
					end
				end
				CMD_CLEAR: begin
					k = held_events.size();
					held_events.delete();
					add_beat(STAT_OK, blank, 1'b0, k, 1'b1);
				end
				CMD_COMPARE: begin
					if (held_events.size() == 0)
						add_beat(STAT_EMPTY, blank, 1'b0, 0, 1'b1);
					else
						add_beat(STAT_OK, blank,
							ahead_of(held_events[0].sec, held_events[0].nsec, s, ns),
							held_events.size(), 1'b1);
				end
				default: begin
				end
			endcase
		endfunction

		function void check_beat(result_beat_t got);
			result_beat_t want;
			if (due_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: status %0d tag %h sec %h nsec %h earlier %b count %0d last %b",
						got.status, got.tag, got.sec, got.nsec, got.earlier, got.count, got.last);
				return;
			end
			want = due_beats.pop_front();
			if (got.status !== want.status || got.tag !== want.tag || got.sec !== want.sec ||
					got.nsec !== want.nsec || got.earlier !== want.earlier ||
					got.count !== want.count || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("beat mismatch at %0t", $realtime);
					$display("  expected status %0d tag %h sec %h nsec %h earlier %b count %0d last %b",
						want.status, want.tag, want.sec, want.nsec, want.earlier, want.count,
						want.last);
					$display("  actual   status %0d tag %h sec %h nsec %h earlier %b count %0d last %b",
						got.status, got.tag, got.sec, got.nsec, got.earlier, got.count, got.last);
				end
			end
		endfunction

		function int outstanding();
			return due_beats.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	teq_req_if req_ch ();
	teq_rsp_if rsp_ch ();

	event_scoreboard sb = new();
	int burst_left = 0;
	bit steady = 0;
	bit squeeze = 0;
	int sent_items = 0;

	timed_event_queue_core #(
		.DEPTH(DEPTH),
		.TAG_BITS(TAG_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Lowers valid for a random gap once the current burst runs out.
	task automatic pace();
		if (!steady) begin
			if (burst_left == 0) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) :
					$urandom_range(1, 8);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [SEC_W-1:0] s,
			input logic [NSEC_W-1:0] ns, input logic [TAG_W-1:0] tg);
		req_ch.valid <= 1'b1;
		req_ch.cmd <= c;
		req_ch.time_sec <= s;
		req_ch.time_nsec <= ns;
		req_ch.tag <= tg;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_command(c, s, ns, tg);
		if (c <= CMD_COMPARE)
			sent_items++;
		pace();
	endtask

	// Mostly a few seconds apart with coarse nanoseconds, so ties and not-yet-due heads are common.
	task automatic pick_stamp(output logic [SEC_W-1:0] s, output logic [NSEC_W-1:0] ns);
		case ($urandom_range(0, 9))
			0: begin
				s = $urandom();
				ns = NSEC_W'($urandom());
			end
			1: begin
				s = $urandom_range(0, 1) ? '1 : '0;
				case ($urandom_range(0, 3))
					0: ns = '0;
					1: ns = '1;
					2: ns = NSEC_LEGAL_MAX;
					default: ns = NSEC_LEGAL_MAX + 30'd1;
				endcase
			end
			default: begin
				s = $urandom_range(0, 7);
				ns = ($urandom_range(0, 1) == 0) ? 30'($urandom_range(0, 3) * 250_000_000) :
					30'($urandom_range(0, 999_999_999));
			end
		endcase
	endtask

	initial begin
		logic [SEC_W-1:0] s;
		logic [NSEC_W-1:0] ns;
		int phase;
		int n;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_INSERT;
		req_ch.time_sec <= '0;
		req_ch.time_nsec <= '0;
		req_ch.tag <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty-queue behavior of pop, release, compare and clear, then the ignored codes.
		send_cmd(CMD_POP, 32'd1, 30'd1, 16'h1111);
		send_cmd(CMD_RELEASE, '1, '1, 16'h2222);
		send_cmd(CMD_COMPARE, '1, '1, 16'h3333);
		send_cmd(CMD_CLEAR, '0, '0, '0);
		for (int c = CMD_UNUSED_FIRST; c < (1 << CMD_W); c++)
			send_cmd(CMD_W'(c), $urandom(), NSEC_W'($urandom()), TAG_W'($urandom()));
		// Extreme stamps, an out-of-range nanosecond value, and a run of equal times.
		send_cmd(CMD_INSERT, '1, '1, 16'hFFFF);
		send_cmd(CMD_INSERT, '0, '0, 16'h0000);
		send_cmd(CMD_INSERT, 32'd5, NSEC_LEGAL_MAX + 30'd1, 16'h0001);
		send_cmd(CMD_INSERT, 32'd5, NSEC_LEGAL_MAX, 16'h0002);
		send_cmd(CMD_INSERT, 32'd5, NSEC_LEGAL_MAX, 16'h0003);
		send_cmd(CMD_INSERT, 32'd5, NSEC_LEGAL_MAX, 16'h0004);
		send_cmd(CMD_COMPARE, '0, '0, '0);
		send_cmd(CMD_COMPARE, '0, 30'd1, '0);
		send_cmd(CMD_RELEASE, '0, '0, '0);
		send_cmd(CMD_RELEASE, 32'd4, '1, '0);
		send_cmd(CMD_RELEASE, 32'd5, NSEC_LEGAL_MAX, '0);
		send_cmd(CMD_POP, '0, '0, '0);
		send_cmd(CMD_COMPARE, '1, '1, '0);
		send_cmd(CMD_INSERT, 32'h8000_0000, 30'h2000_0000, 16'h8000);
		send_cmd(CMD_RELEASE, '1, '1, '0);
		send_cmd(CMD_INSERT, 32'd3, 30'd7, 16'h5A5A);
		send_cmd(CMD_CLEAR, '0, '0, '0);

		phase = 0;
		while (sent_items < RANDOM_ITEMS) begin
			if (phase == 2) begin
				// Receiver holds off while the sender keeps offering beats; the queue is then
				// offered more inserts than its depth holds and drained by one large release.
				steady = 1;
				squeeze = 1;
				send_cmd(CMD_CLEAR, $urandom(), NSEC_W'($urandom()), TAG_W'($urandom()));
				repeat (DEPTH + 2) begin
					pick_stamp(s, ns);
					send_cmd(CMD_INSERT, s, ns, TAG_W'($urandom()));
				end
				steady = 0;
				send_cmd(CMD_RELEASE, '1, '1, TAG_W'($urandom()));
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						n = $urandom_range(1, 20);
						repeat (n) begin
							pick_stamp(s, ns);
							send_cmd(CMD_INSERT, s, ns, TAG_W'($urandom()));
						end
					end
					4, 5: begin
						pick_stamp(s, ns);
						send_cmd(CMD_RELEASE, s, ns, TAG_W'($urandom()));
					end
					6: begin
						repeat ($urandom_range(1, 3))
							send_cmd(CMD_POP, $urandom(), NSEC_W'($urandom()),
								TAG_W'($urandom()));
					end
					7: begin
						repeat ($urandom_range(1, 3)) begin
							pick_stamp(s, ns);
							send_cmd(CMD_COMPARE, s, ns, TAG_W'($urandom()));
						end
					end
					8: begin
						if ($urandom_range(0, 1) == 0)
							send_cmd(CMD_CLEAR, $urandom(), NSEC_W'($urandom()),
								TAG_W'($urandom()));
						else
							send_cmd(CMD_COMPARE, $urandom(), NSEC_W'($urandom()),
								TAG_W'($urandom()));
					end
					default: begin
						send_cmd(CMD_W'($urandom_range(CMD_UNUSED_FIRST, (1 << CMD_W) - 1)),
							$urandom(), NSEC_W'($urandom()), TAG_W'($urandom()));
					end
				endcase
			end
			phase++;
		end

		req_ch.valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Result side: checks each accepted beat and drives ready in changing patterns.
	initial begin
		result_beat_t got;
		int mode;
		int mode_left;
		int tick;
		mode = 0;
		mode_left = 0;
		tick = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status = rsp_ch.status;
				got.tag = rsp_ch.out_tag;
				got.sec = rsp_ch.out_sec;
				got.nsec = rsp_ch.out_nsec;
				got.earlier = rsp_ch.earlier;
				got.count = rsp_ch.count;
				got.last = rsp_ch.last;
				sb.check_beat(got);
			end
			if (squeeze) begin
				rsp_ch.ready <= 1'b0;
				for (int h = 0; h < HOLD_CYCLES; h++)
					@(posedge clk);
				squeeze = 0;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			tick++;
			case (mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= 1'($urandom_range(0, 1));
				2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ch.ready <= (tick % 5) != 0;
			endcase
		end
	end

	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

endmodule
